FILE: hdl/bfs_pkg.sv
// ----------------------------------------------------------------------------
// BFS shortest path package
// Shared types and constants of the breadth-first shortest path engine.
// ----------------------------------------------------------------------------
package bfs_pkg;

   localparam int unsigned VertexWidth = 5;
   localparam int unsigned MAX_VERTEX = 31;

   typedef logic [VertexWidth-1:0] vertex_type;

   typedef enum logic [0:0] {
      OP_ADD_EDGE = 1'b0,
      OP_QUERY    = 1'b1
   } op_type;

   typedef enum logic [0:0] {
      REG_VERTEX_COUNT = 1'b0
   } reg_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EDGE,
      ST_DEQ,
      ST_ROW,
      ST_SCAN,
      ST_WALK_RD,
      ST_WALK,
      ST_EMIT_RD,
      ST_EMIT,
      ST_FAIL
   } state_type;

endpackage

FILE: hdl/bfs_shortest_path_matrix_top.sv
// ----------------------------------------------------------------------------
// BFS shortest path engine
// Adjacency bit matrix with a breadth-first search that emits the path.
// ----------------------------------------------------------------------------
// channel   direction  handshake          payload
// req       in         start / busy       req_operation, req_from_vertex, req_to_vertex
// rsp       out        rsp_valid strobe   rsp_path_vertex, rsp_found, rsp_last
// csr       in/out     APB write/read     vertex_count at address 0
//
// A stored edge word reads its row in ST_IDLE and writes it in ST_EDGE; an ignored
// edge word or a one-vertex query finishes in ST_IDLE, and an out-of-range query
// goes through ST_FAIL. A search dequeues each vertex in ST_DEQ and ST_ROW, scans
// the vertex indices in ST_SCAN, walks the predecessors in ST_WALK and ST_WALK_RD
// and emits each word through ST_EMIT_RD and ST_EMIT, paced by the registered reads.
// Reset is synchronous; after it busy stays high while the matrix
// is cleared one row per cycle. The receiver cannot stall results.
module bfs_shortest_path_matrix_top
   import bfs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_operation,
   input  logic [4:0]  req_from_vertex,
   input  logic [4:0]  req_to_vertex,
   output logic        rsp_valid,
   output logic [4:0]  rsp_path_vertex,
   output logic        rsp_found,
   output logic        rsp_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int unsigned Depth = MAX_VERTEX + 1;
   localparam int unsigned AddrWidth = $clog2(Depth);
   localparam int unsigned CountWidth = $clog2(Depth + 1);

   logic [MAX_VERTEX:0] edge_mem [Depth];
   vertex_type          pred_mem [Depth];
   vertex_type          queue_mem [Depth];
   vertex_type          stack_mem [Depth];

   state_type state_ff, state_in;
   vertex_type vcount_ff;
   vertex_type src_ff, dst_ff, src_in, dst_in;
   logic [MAX_VERTEX:0] visited_ff, visited_in, row_ff;
   logic [CountWidth-1:0] head_ff, head_in, tail_ff, tail_in, len_ff, len_in;
   vertex_type u_ff, u_in, scan_ff, scan_in, cur_ff, cur_in;
   logic [4:0] n_active;
   vertex_type queue_rd_ff, pred_rd_ff, stack_rd_ff;

   logic accept;
   logic edge_we;
   logic [AddrWidth-1:0] edge_waddr, edge_raddr;
   logic [MAX_VERTEX:0] edge_wbit, edge_wdata;
   logic pred_we, queue_we, stack_we;
   logic [AddrWidth-1:0] pred_waddr, pred_raddr, queue_waddr, queue_raddr;
   logic [AddrWidth-1:0] stack_waddr, stack_raddr;
   vertex_type pred_wdata, queue_wdata, stack_wdata;
   logic out_valid_in, out_found_in, out_last_in;
   vertex_type out_vertex_in;
   logic out_valid_ff, out_found_ff, out_last_ff;
   vertex_type out_vertex_ff;
   logic hit;
   logic clear_ff;
   logic [AddrWidth:0] clr_ff;

   assign pready = 1'b1;
   assign prdata = {27'd0, vcount_ff};
   assign busy = (state_ff != ST_IDLE) || clear_ff;
   assign accept = start && !busy;
   assign n_active = (32'(vcount_ff) > MAX_VERTEX) ? 5'(MAX_VERTEX) : vcount_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= 5'd31;
      end else if (psel && penable && pwrite && pready &&
                   paddr[2] == REG_VERTEX_COUNT) begin
         vcount_ff <= pwdata[4:0];
      end
   end

   always_ff @(posedge clock) begin
      if (clear_ff) begin
         edge_mem[clr_ff[AddrWidth-1:0]] <= '0;
      end else if (edge_we) begin
         edge_mem[edge_waddr] <= edge_wdata;
      end
      row_ff <= edge_mem[edge_raddr];
      if (pred_we) begin
         pred_mem[pred_waddr] <= pred_wdata;
      end
      pred_rd_ff <= pred_mem[pred_raddr];
      if (queue_we) begin
         queue_mem[queue_waddr] <= queue_wdata;
      end
      queue_rd_ff <= queue_mem[queue_raddr];
      if (stack_we) begin
         stack_mem[stack_waddr] <= stack_wdata;
      end
      stack_rd_ff <= stack_mem[stack_raddr];
   end

   // The matrix is cleared by a sweep after reset: edge_mem has no reset value
   // otherwise, so the clearing state writes one row per cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff <= 1'b1;
         clr_ff <= '0;
      end else if (clear_ff) begin
         clr_ff <= clr_ff + 1'b1;
         if (clr_ff == (AddrWidth+1)'(Depth - 1)) begin
            clear_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      src_in = src_ff;
      dst_in = dst_ff;
      visited_in = visited_ff;
      head_in = head_ff;
      tail_in = tail_ff;
      len_in = len_ff;
      u_in = u_ff;
      scan_in = scan_ff;
      cur_in = cur_ff;
      edge_we = 1'b0;
      edge_waddr = AddrWidth'(src_ff);
      edge_wbit = (MAX_VERTEX+1)'(1) << dst_ff;
      edge_wdata = row_ff | edge_wbit;
      edge_raddr = AddrWidth'(u_ff);
      pred_we = 1'b0;
      pred_waddr = AddrWidth'(scan_ff);
      pred_wdata = u_ff;
      pred_raddr = AddrWidth'(cur_ff);
      queue_we = 1'b0;
      queue_waddr = tail_ff[AddrWidth-1:0];
      queue_wdata = scan_ff;
      queue_raddr = head_ff[AddrWidth-1:0];
      stack_we = 1'b0;
      stack_waddr = len_ff[AddrWidth-1:0];
      stack_wdata = cur_ff;
      stack_raddr = AddrWidth'(len_ff - 1'b1);
      out_valid_in = 1'b0;
      out_vertex_in = '0;
      out_found_in = 1'b0;
      out_last_in = 1'b1;
      hit = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               src_in = req_from_vertex;
               dst_in = req_to_vertex;
               if (req_operation == OP_ADD_EDGE) begin
                  if (req_from_vertex != 0 && 32'(req_from_vertex) <= MAX_VERTEX &&
                      req_to_vertex != 0 && 32'(req_to_vertex) <= MAX_VERTEX) begin
                     edge_raddr = AddrWidth'(req_from_vertex);
                     state_in = ST_EDGE;
                  end
               end else if (req_from_vertex == 0 || req_from_vertex > n_active ||
                            req_to_vertex == 0 || req_to_vertex > n_active) begin
                  state_in = ST_FAIL;
               end else if (req_from_vertex == req_to_vertex) begin
                  out_valid_in = 1'b1;
                  out_vertex_in = req_from_vertex;
                  out_found_in = 1'b1;
               end else begin
                  visited_in = (MAX_VERTEX+1)'(1) << req_from_vertex;
                  queue_we = 1'b1;
                  queue_waddr = '0;
                  queue_wdata = req_from_vertex;
                  head_in = '0;
                  tail_in = CountWidth'(1);
                  state_in = ST_DEQ;
               end
            end
         end
         ST_EDGE: begin
            edge_we = 1'b1;
            state_in = ST_IDLE;
         end
         ST_DEQ: begin
            if (head_ff < tail_ff && 32'(head_ff) <= MAX_VERTEX) begin
               state_in = ST_ROW;
               head_in = head_ff + 1'b1;
            end else begin
               state_in = ST_FAIL;
            end
         end
         ST_ROW: begin
            u_in = queue_rd_ff;
            edge_raddr = AddrWidth'(queue_rd_ff);
            scan_in = 5'd1;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_ff > n_active) begin
               state_in = ST_DEQ;
            end else begin
               scan_in = scan_ff + 1'b1;
               if (!visited_ff[scan_ff] && row_ff[scan_ff]) begin
                  visited_in = visited_ff | ((MAX_VERTEX+1)'(1) << scan_ff);
                  pred_we = 1'b1;
                  if (32'(tail_ff) <= MAX_VERTEX) begin
                     queue_we = 1'b1;
                     tail_in = tail_ff + 1'b1;
                  end
                  if (scan_ff == dst_ff) begin
                     hit = 1'b1;
                     cur_in = dst_ff;
                     len_in = '0;
                     state_in = ST_WALK;
                  end
               end
               if (scan_ff == 5'd31) begin
                  if (!hit) state_in = ST_DEQ;
               end
            end
         end
         ST_WALK: begin
            stack_we = 1'b1;
            len_in = len_ff + 1'b1;
            if (cur_ff == src_ff || 32'(len_ff) + 1 > MAX_VERTEX) begin
               state_in = ST_EMIT_RD;
            end else begin
               state_in = ST_WALK_RD;
            end
         end
         ST_WALK_RD: begin
            state_in = ST_WALK;
            cur_in = pred_rd_ff;
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            out_valid_in = 1'b1;
            out_vertex_in = stack_rd_ff;
            out_found_in = 1'b1;
            out_last_in = (len_ff == CountWidth'(1));
            len_in = len_ff - 1'b1;
            state_in = (len_ff == CountWidth'(1)) ? ST_IDLE : ST_EMIT_RD;
         end
         ST_FAIL: begin
            out_valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // The walk reads the predecessor of the current vertex in ST_WALK; ST_WALK_RD takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff <= src_in;
      dst_ff <= dst_in;
      visited_ff <= visited_in;
      head_ff <= head_in;
      tail_ff <= tail_in;
      len_ff <= len_in;
      u_ff <= u_in;
      scan_ff <= scan_in;
      cur_ff <= cur_in;
      out_vertex_ff <= out_vertex_in;
      out_found_ff <= out_found_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_path_vertex = out_vertex_ff;
   assign rsp_found = out_found_ff;
   assign rsp_last = out_last_ff;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_last && rsp_path_vertex == 5'd0)
      else $error("failed search word not final or nonzero");
   assert property (@(posedge clock) disable iff (reset)
      accept |=> !rsp_valid || rsp_last || busy)
      else $error("word order broken after accept");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |=> !busy || $past(accept))
      else $error("busy after final word");

endmodule

FILE: test/tb_bfs_shortest_path_matrix_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BFS shortest path engine testbench
// Drives edge and path query words with random gaps, rewrites the vertex
// count between phases, and checks every path word against a local search.
// ----------------------------------------------------------------------------
module tb_bfs_shortest_path_matrix_top;
   import bfs_pkg::*;

   localparam int unsigned MaxVertex = 31;

   typedef struct packed {
      logic [4:0] path_vertex;
      logic       found;
      logic       last;
   } path_word_type;

   typedef struct packed {
      op_type     operation;
      logic [4:0] from_vertex;
      logic [4:0] to_vertex;
      logic       has_check;
      logic [4:0] check_vertex;
      logic       check_found;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_operation;
   logic [4:0]  req_from_vertex;
   logic [4:0]  req_to_vertex;
   logic        rsp_valid;
   logic [4:0]  rsp_path_vertex;
   logic        rsp_found;
   logic        rsp_last;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   logic [31:0]   adjacency [0:31];
   logic [4:0]    vertex_limit;
   path_word_type path_words_due [$];
   path_word_type last_predicted;
   int            mismatch_count;
   int            unmatched_count;

   bfs_shortest_path_matrix_top u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_operation(req_operation), .req_from_vertex(req_from_vertex),
      .req_to_vertex(req_to_vertex), .rsp_valid(rsp_valid),
      .rsp_path_vertex(rsp_path_vertex), .rsp_found(rsp_found), .rsp_last(rsp_last),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   function automatic void queue_word(input path_word_type word);
      path_words_due = {path_words_due, word};
      last_predicted = word;
   endfunction

   function automatic void predict_path(input op_type op, input logic [4:0] src,
                                        input logic [4:0] dst);
      logic [31:0] seen;
      logic [4:0]  pred [0:31];
      logic [4:0]  fifo [$];
      logic [4:0]  path [$];
      logic [4:0]  u;
      logic [4:0]  c;
      int          n;
      bit          hit;
      n = (vertex_limit > MaxVertex) ? MaxVertex : vertex_limit;
      hit = 1'b0;
      if (op == OP_ADD_EDGE) begin
         if (src != 0 && dst != 0)
            adjacency[src][dst] = 1'b1;
         return;
      end
      if (src == 0 || src > n || dst == 0 || dst > n) begin
         queue_word('{5'd0, 1'b0, 1'b1});
         return;
      end
      if (src == dst) begin
         queue_word('{src, 1'b1, 1'b1});
         return;
      end
      seen = 32'd1 << src;
      fifo = {fifo, src};
      while (fifo.size() > 0 && !hit) begin
         u = fifo.pop_front();
         for (int i = 1; i <= n && !hit; i++) begin
            if (!seen[i] && adjacency[u][i]) begin
               seen[i] = 1'b1;
               pred[i] = u;
               fifo = {fifo, 5'(i)};
               if (i == dst)
                  hit = 1'b1;
            end
         end
      end
      if (!hit) begin
         queue_word('{5'd0, 1'b0, 1'b1});
         return;
      end
      c = dst;
      path.push_front(c);
      while (c != src) begin
         c = pred[c];
         path.push_front(c);
      end
      foreach (path[k])
         queue_word('{path[k], 1'b1, k == path.size() - 1});
   endfunction

   always @(posedge clock) begin
      path_word_type seen_word;
      path_word_type due_word;
      if (!reset && rsp_valid) begin
         seen_word = '{rsp_path_vertex, rsp_found, rsp_last};
         if (path_words_due.size() == 0) begin
            unmatched_count++;
            if (mismatch_count + unmatched_count <= 10)
               $display("unexpected path word %p", seen_word);
         end else begin
            due_word = path_words_due.pop_front();
            if (seen_word !== due_word) begin
               mismatch_count++;
               if (mismatch_count + unmatched_count <= 10)
                  $display("path word mismatch: expected %p, got %p", due_word, seen_word);
            end
         end
      end
   end

   task automatic idle_gap();
      int gap;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0)
         gap = 0;
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_word(input op_type op, input logic [4:0] src,
                            input logic [4:0] dst);
      start <= 1'b1;
      req_operation <= op;
      req_from_vertex <= src;
      req_to_vertex <= dst;
      predict_path(op, src, dst);
      @(negedge clock);
      while (busy)
         @(negedge clock);
      @(posedge clock);
      idle_gap();
   endtask

   task automatic write_vertex_count(input logic [4:0] value);
      start <= 1'b0;
      while (path_words_due.size() != 0)
         @(posedge clock);
      repeat (140) @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= 3'(4 * REG_VERTEX_COUNT);
      pwdata <= 32'(value);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      vertex_limit = value;
      @(posedge clock);
   endtask

   task automatic run_random(input int count, input int span);
      logic [4:0] a;
      logic [4:0] b;
      for (int i = 0; i < count; i++) begin
         a = 5'($urandom_range(1, span));
         b = 5'($urandom_range(1, span));
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: send_word(OP_ADD_EDGE, a, b);
            5: send_word(op_type'($urandom_range(0, 1)), 5'($urandom), 5'($urandom));
            default: send_word(OP_QUERY, a, b);
         endcase
      end
   endtask

   initial begin
      #200000000;
      $display("bfs_shortest_path_matrix_top verification failed");
      $finish;
   end

   initial begin
      stim_row_type table_rows [$];
      int           drained;
      table_rows = '{
         '{OP_QUERY, 5'd1, 5'd2, 1'b1, 5'd0, 1'b0},
         '{OP_QUERY, 5'd0, 5'd1, 1'b1, 5'd0, 1'b0},
         '{OP_QUERY, 5'd31, 5'd0, 1'b1, 5'd0, 1'b0},
         '{OP_QUERY, 5'd31, 5'd31, 1'b1, 5'd31, 1'b1},
         '{OP_ADD_EDGE, 5'd0, 5'd3, 1'b0, 5'd0, 1'b0},
         '{OP_ADD_EDGE, 5'd1, 5'd2, 1'b0, 5'd0, 1'b0},
         '{OP_ADD_EDGE, 5'd2, 5'd2, 1'b0, 5'd0, 1'b0},
         '{OP_ADD_EDGE, 5'd2, 5'd31, 1'b0, 5'd0, 1'b0},
         '{OP_ADD_EDGE, 5'd1, 5'd30, 1'b0, 5'd0, 1'b0},
         '{OP_ADD_EDGE, 5'd30, 5'd31, 1'b0, 5'd0, 1'b0},
         '{OP_ADD_EDGE, 5'd31, 5'd0, 1'b0, 5'd0, 1'b0},
         '{OP_QUERY, 5'd1, 5'd31, 1'b0, 5'd0, 1'b0},
         '{OP_QUERY, 5'd31, 5'd1, 1'b1, 5'd0, 1'b0},
         '{OP_QUERY, 5'd2, 5'd2, 1'b1, 5'd2, 1'b1},
         '{OP_QUERY, 5'd1, 5'd2, 1'b0, 5'd0, 1'b0}
      };
      mismatch_count = 0;
      unmatched_count = 0;
      vertex_limit = 5'd31;
      last_predicted = '0;
      foreach (adjacency[i])
         adjacency[i] = '0;
      reset = 1'b1;
      start = 1'b0;
      req_operation = OP_ADD_EDGE;
      req_from_vertex = '0;
      req_to_vertex = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (table_rows[i]) begin
         send_word(table_rows[i].operation, table_rows[i].from_vertex,
                   table_rows[i].to_vertex);
         if (table_rows[i].has_check
             && last_predicted !== path_word_type'{table_rows[i].check_vertex,
                                                   table_rows[i].check_found,
                                                   1'b1}) begin
            mismatch_count++;
            if (mismatch_count + unmatched_count <= 10)
               $display("table row %0d predicts %p", i, last_predicted);
         end
      end
      // The long edge chain stays but falls outside a short vertex count.
      write_vertex_count(5'd2);
      send_word(OP_QUERY, 5'd1, 5'd2);
      send_word(OP_QUERY, 5'd1, 5'd31);
      write_vertex_count(5'd0);
      send_word(OP_QUERY, 5'd1, 5'd1);
      write_vertex_count(5'd1);
      send_word(OP_QUERY, 5'd1, 5'd1);
      write_vertex_count(5'd8);
      run_random(100, 10);
      write_vertex_count(5'd31);
      for (int v = 3; v < 31; v++)
         send_word(OP_ADD_EDGE, 5'(v), 5'(v + 1));
      send_word(OP_QUERY, 5'd1, 5'd31);
      run_random(120, 31);
      write_vertex_count(5'd20);
      run_random(100, 31);
      start <= 1'b0;

      drained = 0;
      while (path_words_due.size() != 0 && drained < 100000) begin
         @(posedge clock);
         drained++;
      end
      repeat (200) @(posedge clock);
      if (mismatch_count == 0 && unmatched_count == 0 && path_words_due.size() == 0)
         $display("bfs_shortest_path_matrix_top verification clean");
      else
         $display("bfs_shortest_path_matrix_top verification failed");
      $finish;
   end

endmodule
